### sv/ebfa_pkg.sv
// Package for the exponent-binned double accumulator.
// Holds opcodes, the queued item type, state types and IEEE constants.
// No dependencies.
package ebfa_pkg;

    localparam logic OP_ACC  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam int EXP_W  = 11;
    localparam int FRAC_W = 52;

    localparam logic [EXP_W-1:0] EXP_MAX   = 11'h7FF;
    localparam logic [63:0]      CANON_NAN = 64'h7FF8_0000_0000_0000;

    typedef struct packed {
        logic             op;
        logic [EXP_W-1:0] bin;
        logic [63:0]      value;
    } t_item;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_ACC_RD,
        B_ACC_WAIT,
        B_SUM_RD,
        B_SUM_WAIT
    } t_bstate;

    typedef enum logic [2:0] {
        A_IDLE,
        A_ALIGN,
        A_ADD,
        A_NORM,
        A_ROUND
    } t_astate;

endpackage

### sv/ebfa_front.sv
// Front end: accepts items, maps each value to its bin, and queues them.
// Depends on ebfa_pkg.
module ebfa_front #(
    parameter int BIN_COUNT = 2048
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_opcode,
    input  logic [63:0]         i_value,
    input  logic                i_clearing,
    input  logic                i_pop,
    output logic                o_head_valid,
    output ebfa_pkg::t_item     o_head
);

    ebfa_pkg::t_item        r_q [2];
    logic [1:0]             r_cnt;
    ebfa_pkg::t_item        w_new;
    logic                   w_push;
    logic [ebfa_pkg::EXP_W-1:0] w_exp;
    logic                   w_sat;

    assign w_exp = i_value[62:52];
    assign w_sat = {1'b0, w_exp} >= 12'(BIN_COUNT);

    always_comb begin
        w_new.op    = i_opcode;
        w_new.bin   = w_sat ? ebfa_pkg::EXP_W'(BIN_COUNT - 1) : w_exp;
        w_new.value = i_value;
    end

    assign busy         = (r_cnt == 2'd2) || i_clearing;
    assign w_push       = start && !busy;
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_q[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            if (w_push && i_pop) begin
                r_cnt <= r_cnt;
            end else if (w_push) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push && i_pop) begin
            if (r_cnt == 2'd1) begin
                r_q[0] <= w_new;
            end else begin
                r_q[0] <= r_q[1];
                r_q[1] <= w_new;
            end
        end else if (w_push) begin
            r_q[r_cnt[0]] <= w_new;
        end else if (i_pop) begin
            r_q[0] <= r_q[1];
        end
    end

endmodule

### sv/ebfa_fpadd.sv
// Multi-cycle IEEE double adder, round to nearest even.
// Depends on ebfa_pkg.
module ebfa_fpadd (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_res
);

    ebfa_pkg::t_astate r_state, n_state;

    logic [63:0] r_a, r_b;
    logic        r_special;
    logic [63:0] r_spec_res;
    logic        r_sign, r_zsign, r_sub;
    logic [52:0] r_mbig, r_msml;
    logic [11:0] r_e;
    logic [10:0] r_d;
    logic [55:0] r_m;
    logic        r_done;
    logic [63:0] r_res;

    logic        w_a_swap;
    logic [63:0] w_big, w_sml;
    logic        w_a_nan, w_b_nan, w_a_inf, w_b_inf;
    logic [10:0] w_ebig, w_esml;

    logic [55:0] w_m56, w_lost, w_sh;
    logic [56:0] w_sum;

    logic        w_inc;
    logic [53:0] w_mr;
    logic [52:0] w_mant;
    logic [11:0] w_efin;
    logic [63:0] w_packed;

    assign o_done = r_done;
    assign o_res  = r_res;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ebfa_pkg::A_IDLE:  if (i_start) n_state = ebfa_pkg::A_ALIGN;
            ebfa_pkg::A_ALIGN: n_state = ebfa_pkg::A_ADD;
            ebfa_pkg::A_ADD:   n_state = ebfa_pkg::A_NORM;
            ebfa_pkg::A_NORM: begin
                if (r_m[55] || r_m == 56'd0 || r_e <= 12'd1) n_state = ebfa_pkg::A_ROUND;
            end
            ebfa_pkg::A_ROUND: n_state = ebfa_pkg::A_IDLE;
            default:           n_state = ebfa_pkg::A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ebfa_pkg::A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ebfa_pkg::A_ROUND);
        end
    end

    // unpack and order by magnitude
    always_comb begin
        w_a_swap = r_a[62:0] < r_b[62:0];
        w_big    = w_a_swap ? r_b : r_a;
        w_sml    = w_a_swap ? r_a : r_b;
        w_a_nan  = (r_a[62:52] == ebfa_pkg::EXP_MAX) && (r_a[51:0] != 52'd0);
        w_b_nan  = (r_b[62:52] == ebfa_pkg::EXP_MAX) && (r_b[51:0] != 52'd0);
        w_a_inf  = (r_a[62:52] == ebfa_pkg::EXP_MAX) && (r_a[51:0] == 52'd0);
        w_b_inf  = (r_b[62:52] == ebfa_pkg::EXP_MAX) && (r_b[51:0] == 52'd0);
        w_ebig   = (w_big[62:52] == 11'd0) ? 11'd1 : w_big[62:52];
        w_esml   = (w_sml[62:52] == 11'd0) ? 11'd1 : w_sml[62:52];
    end

    // align with sticky, then add or subtract
    always_comb begin
        w_m56  = {r_msml, 3'b000};
        w_lost = w_m56 & ~({56{1'b1}} << r_d);
        if (r_d >= 11'd56) begin
            w_sh = {55'd0, |r_msml};
        end else begin
            w_sh = (w_m56 >> r_d) | {55'd0, |w_lost};
        end
        if (r_sub) begin
            w_sum = {1'b0, r_mbig, 3'b000} - {1'b0, w_sh};
        end else begin
            w_sum = {1'b0, r_mbig, 3'b000} + {1'b0, w_sh};
        end
    end

    // round and pack
    always_comb begin
        w_inc = r_m[2] && (r_m[1] || r_m[0] || r_m[3]);
        w_mr  = {1'b0, r_m[55:3]} + 54'(w_inc);
        if (w_mr[53]) begin
            w_mant = w_mr[53:1];
            w_efin = r_e + 12'd1;
        end else begin
            w_mant = w_mr[52:0];
            w_efin = r_e;
        end
        if (r_m == 56'd0) begin
            w_packed = {r_zsign, 63'd0};
        end else if (w_efin >= 12'd2047) begin
            w_packed = {r_sign, ebfa_pkg::EXP_MAX, 52'd0};
        end else begin
            w_packed = {r_sign, (w_mant[52] ? w_efin[10:0] : 11'd0), w_mant[51:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ebfa_pkg::A_IDLE: begin
                r_a <= i_a;
                r_b <= i_b;
            end
            ebfa_pkg::A_ALIGN: begin
                r_special <= (r_a[62:52] == ebfa_pkg::EXP_MAX)
                          || (r_b[62:52] == ebfa_pkg::EXP_MAX);
                if (w_a_nan || w_b_nan || (w_a_inf && w_b_inf && (r_a[63] != r_b[63]))) begin
                    r_spec_res <= ebfa_pkg::CANON_NAN;
                end else if (w_a_inf) begin
                    r_spec_res <= r_a;
                end else begin
                    r_spec_res <= r_b;
                end
                r_sign  <= w_big[63];
                r_zsign <= r_a[63] && r_b[63];
                r_sub   <= r_a[63] != r_b[63];
                r_mbig  <= {w_big[62:52] != 11'd0, w_big[51:0]};
                r_msml  <= {w_sml[62:52] != 11'd0, w_sml[51:0]};
                r_e     <= {1'b0, w_ebig};
                r_d     <= w_ebig - w_esml;
            end
            ebfa_pkg::A_ADD: begin
                if (w_sum[56]) begin
                    r_m <= {w_sum[56:2], w_sum[1] | w_sum[0]};
                    r_e <= r_e + 12'd1;
                end else begin
                    r_m <= w_sum[55:0];
                end
            end
            ebfa_pkg::A_NORM: begin
                if (!r_m[55] && r_m != 56'd0 && r_e > 12'd1) begin
                    r_m <= r_m << 1;
                    r_e <= r_e - 12'd1;
                end
            end
            ebfa_pkg::A_ROUND: begin
                r_res <= r_special ? r_spec_res : w_packed;
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

endmodule

### sv/ebfa_back.sv
// Back end: bin memory, clearing pass, accumulate and summing sequencer.
// Depends on ebfa_pkg and ebfa_fpadd.
module ebfa_back #(
    parameter int BIN_COUNT = 2048
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  ebfa_pkg::t_item i_head,
    output logic            o_pop,
    output logic            o_clearing,
    output logic            o_done,
    output logic [63:0]     o_total
);

    localparam int BIN_W = $clog2(BIN_COUNT);
    localparam logic [BIN_W-1:0] LAST = BIN_W'(BIN_COUNT - 1);

    ebfa_pkg::t_bstate r_state, n_state;

    logic [63:0]      r_mem [BIN_COUNT];
    logic [63:0]      r_rdata;
    logic [BIN_W-1:0] r_idx;
    logic [BIN_W-1:0] r_bin;
    logic [63:0]      r_val;
    logic [63:0]      r_sum;
    logic             r_done;
    logic [63:0]      r_total;

    logic [BIN_W-1:0] w_raddr;
    logic             w_we;
    logic [BIN_W-1:0] w_waddr;
    logic [63:0]      w_wdata;
    logic             w_add_start;
    logic [63:0]      w_add_a, w_add_b;
    logic             w_add_done;
    logic [63:0]      w_add_res;

    ebfa_fpadd u_add (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_add_start),
        .i_a     (w_add_a),
        .i_b     (w_add_b),
        .o_done  (w_add_done),
        .o_res   (w_add_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ebfa_pkg::B_CLEAR: if (r_idx == LAST) n_state = ebfa_pkg::B_IDLE;
            ebfa_pkg::B_IDLE: begin
                if (i_head_valid) begin
                    n_state = (i_head.op == ebfa_pkg::OP_ACC) ? ebfa_pkg::B_ACC_RD
                                                              : ebfa_pkg::B_SUM_RD;
                end
            end
            ebfa_pkg::B_ACC_RD:   n_state = ebfa_pkg::B_ACC_WAIT;
            ebfa_pkg::B_ACC_WAIT: if (w_add_done) n_state = ebfa_pkg::B_IDLE;
            ebfa_pkg::B_SUM_RD:   n_state = ebfa_pkg::B_SUM_WAIT;
            ebfa_pkg::B_SUM_WAIT: begin
                if (w_add_done) begin
                    n_state = (r_idx == LAST) ? ebfa_pkg::B_IDLE : ebfa_pkg::B_SUM_RD;
                end
            end
            default: n_state = ebfa_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_clearing  = (r_state == ebfa_pkg::B_CLEAR);
        o_pop       = (r_state == ebfa_pkg::B_IDLE) && i_head_valid;
        w_add_start = (r_state == ebfa_pkg::B_ACC_RD) || (r_state == ebfa_pkg::B_SUM_RD);
        w_add_a     = (r_state == ebfa_pkg::B_ACC_RD) ? r_rdata : r_sum;
        w_add_b     = (r_state == ebfa_pkg::B_ACC_RD) ? r_val : r_rdata;
        w_we        = 1'b0;
        w_waddr     = r_bin;
        w_wdata     = w_add_res;
        if (r_state == ebfa_pkg::B_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_idx;
            w_wdata = 64'd0;
        end else if (r_state == ebfa_pkg::B_ACC_WAIT && w_add_done) begin
            w_we = 1'b1;
        end
        if (r_state == ebfa_pkg::B_SUM_WAIT) begin
            w_raddr = (r_idx == LAST) ? r_idx : r_idx + BIN_W'(1);
        end else if (i_head.op == ebfa_pkg::OP_ACC) begin
            w_raddr = i_head.bin[BIN_W-1:0];
        end else begin
            w_raddr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ebfa_pkg::B_CLEAR;
            r_idx   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            unique case (r_state)
                ebfa_pkg::B_CLEAR: r_idx <= r_idx + BIN_W'(1);
                ebfa_pkg::B_IDLE: begin
                    if (i_head_valid) begin
                        r_idx <= '0;
                        r_bin <= i_head.bin[BIN_W-1:0];
                        r_val <= i_head.value;
                        r_sum <= 64'd0;
                    end
                end
                ebfa_pkg::B_SUM_WAIT: begin
                    if (w_add_done) begin
                        r_sum <= w_add_res;
                        if (r_idx == LAST) begin
                            r_done <= 1'b1;
                            if ((w_add_res[62:52] == ebfa_pkg::EXP_MAX)
                                && (w_add_res[51:0] != 52'd0)) begin
                                r_total <= ebfa_pkg::CANON_NAN;
                            end else begin
                                r_total <= w_add_res;
                            end
                        end else begin
                            r_idx <= r_idx + BIN_W'(1);
                        end
                    end
                end
                default: r_idx <= r_idx;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_total = r_total;

endmodule

### sv/exponent_binned_fp_accumulator.sv
// Top level of the exponent-binned double accumulator.
// Depends on ebfa_pkg, ebfa_front, ebfa_back.
//
// After reset the block clears every bin of its memory with busy high. The
// back end handles an accumulate item by reading its bin, adding the value in
// the multi-cycle double adder (one bit of normalize shift per cycle) and
// writing the bin back. A read fetches every bin from the single memory port
// and adds it to the running sum in order. A two-deep queue lets up to two
// items be taken while the back end works. The total appears on o_total with
// o_done high for a single cycle; it cannot be held off.
module exponent_binned_fp_accumulator #(
    parameter int BIN_COUNT = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_opcode,
    input  logic [63:0] i_value,
    output logic        o_done,
    output logic [63:0] o_total
);

    logic            w_clearing;
    logic            w_pop;
    logic            w_head_valid;
    ebfa_pkg::t_item w_head;

    ebfa_front #(.BIN_COUNT(BIN_COUNT)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_value      (i_value),
        .i_clearing   (w_clearing),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    ebfa_back #(.BIN_COUNT(BIN_COUNT)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_clearing   (w_clearing),
        .o_done       (o_done),
        .o_total      (o_total)
    );

    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> busy) else $error("item accepted during clear");

    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("back-to-back totals");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head_valid && !w_clearing) else $error("pop from empty queue");

endmodule

### dv/exponent_binned_fp_accumulator_tb.sv
// Self-checking testbench for the exponent-binned double accumulator.
// Drives accumulate and read items, predicts each total with native double addition over
// a private bin array, and compares every total. Depends on ebfa_pkg and the block.
`timescale 1ns / 1ps

module exponent_binned_fp_accumulator_tb;

    localparam int BINS = 2048;

    typedef struct {
        logic        op;
        logic [63:0] value;
    } t_acc_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_opcode;
    logic [63:0] i_value;
    logic        o_done;
    logic [63:0] o_total;

    t_acc_item   pending[$];
    logic [63:0] totals_due[$];
    real         bin_sum[BINS];
    int          idle_pct;
    int          n_errors;
    int          n_acc;
    int          n_reads;

    exponent_binned_fp_accumulator #(.BIN_COUNT(BINS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_opcode(i_opcode),
        .i_value (i_value),
        .o_done  (o_done),
        .o_total (o_total)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        n_errors++;
        $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    endtask

    function automatic logic [63:0] bin_total();
        real         s;
        logic [63:0] b;
        s = 0.0;
        for (int k = 0; k < BINS; k++) begin
            s = s + bin_sum[k];
        end
        b = $realtobits(s);
        if (b[62:52] == ebfa_pkg::EXP_MAX && b[51:0] != '0) begin
            b = ebfa_pkg::CANON_NAN;
        end
        return b;
    endfunction

    function automatic logic [63:0] fp(input logic sgn, input logic [10:0] ex,
                                       input logic [51:0] fr);
        return {sgn, ex, fr};
    endfunction

    function automatic logic [63:0] rand_finite();
        logic [10:0] ex;
        if ($urandom_range(0, 99) < 70) begin
            ex = 11'($urandom_range(1000, 1046));
        end else begin
            ex = 11'($urandom_range(0, 2046));
        end
        return fp(1'($urandom), ex, {20'($urandom), 32'($urandom)});
    endfunction

    task automatic add_item(input logic op, input logic [63:0] v);
        t_acc_item it;
        it.op    = op;
        it.value = v;
        pending.insert(pending.size(), it);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            i_opcode <= ebfa_pkg::OP_ACC;
            i_value  <= '0;
        end else if (!start || !busy) begin
            if (pending.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                start    <= 1'b1;
                i_opcode <= pending[0].op;
                i_value  <= pending[0].value;
                void'(pending.pop_front());
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                if (i_opcode == ebfa_pkg::OP_READ) begin
                    totals_due.insert(totals_due.size(), bin_total());
                    n_reads++;
                end else begin
                    bin_sum[i_value[62:52]] = bin_sum[i_value[62:52]] + $bitstoreal(i_value);
                    n_acc++;
                end
            end
            if (o_done) begin
                if (totals_due.size() == 0) begin
                    report("unexpected total", o_total, '0);
                end else begin
                    if (o_total !== totals_due[0]) begin
                        report("total", o_total, totals_due[0]);
                    end
                    void'(totals_due.pop_front());
                end
            end
        end
    end

    task automatic drain();
        wait (pending.size() == 0);
        @(posedge i_clk);
        while (start) begin
            @(posedge i_clk);
        end
        wait (totals_due.size() == 0);
        @(posedge i_clk);
    endtask

    initial begin
        #1_000_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        n_errors = 0;
        n_acc    = 0;
        n_reads  = 0;
        idle_pct = 16;
        for (int k = 0; k < BINS; k++) begin
            bin_sum[k] = 0.0;
        end
        start    = 1'b0;
        i_opcode = ebfa_pkg::OP_ACC;
        i_value  = '0;
        i_rst_n  = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_item(ebfa_pkg::OP_READ, '0);
        add_item(ebfa_pkg::OP_ACC, fp(1'b1, 11'd0, '0));
        add_item(ebfa_pkg::OP_READ, '1);
        add_item(ebfa_pkg::OP_ACC, fp(1'b0, 11'd0, 52'h1));
        add_item(ebfa_pkg::OP_ACC, fp(1'b1, 11'd0, '1));
        add_item(ebfa_pkg::OP_ACC, fp(1'b0, 11'd1, '0));
        add_item(ebfa_pkg::OP_ACC, fp(1'b0, 11'd1023, '0));
        add_item(ebfa_pkg::OP_ACC, fp(1'b1, 11'd1023, '0));
        add_item(ebfa_pkg::OP_ACC, fp(1'b0, 11'd1023, 52'h8_0000_0000_0001));
        add_item(ebfa_pkg::OP_READ, '0);
        add_item(ebfa_pkg::OP_ACC, fp(1'b0, 11'd2046, '1));
        add_item(ebfa_pkg::OP_ACC, fp(1'b1, 11'd2046, '1));
        add_item(ebfa_pkg::OP_ACC, fp(1'b0, 11'd1075, '0));
        add_item(ebfa_pkg::OP_ACC, fp(1'b0, 11'd1023, 52'h1));
        add_item(ebfa_pkg::OP_READ, '0);

        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 16 : (ph == 1) ? 55 : 0;
            for (int n = 0; n < 390; n++) begin
                if ($urandom_range(0, 99) < 4) begin
                    add_item(ebfa_pkg::OP_READ, {32'($urandom), 32'($urandom)});
                end else begin
                    add_item(ebfa_pkg::OP_ACC, rand_finite());
                end
            end
            add_item(ebfa_pkg::OP_READ, '0);
            drain();
        end

        add_item(ebfa_pkg::OP_ACC, fp(1'b0, 11'd2046, '1));
        add_item(ebfa_pkg::OP_ACC, fp(1'b0, 11'd2046, '1));
        add_item(ebfa_pkg::OP_READ, '0);
        add_item(ebfa_pkg::OP_ACC, fp(1'b1, ebfa_pkg::EXP_MAX, '0));
        add_item(ebfa_pkg::OP_READ, '0);
        add_item(ebfa_pkg::OP_ACC, fp(1'b1, ebfa_pkg::EXP_MAX, 52'h1));
        add_item(ebfa_pkg::OP_ACC, fp(1'b1, ebfa_pkg::EXP_MAX, '1));
        add_item(ebfa_pkg::OP_READ, '0);
        drain();

        repeat (200) @(posedge i_clk);
        $display("covered %0d accumulates and %0d reads of the total", n_acc, n_reads);
        $display("three pacing phases plus overflow, infinity and NaN checks, %0d errors",
                 n_errors);
        if (n_errors == 0 && totals_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
